// ----- rtl/hip_pkg.sv -----
`timescale 1ns / 1ps

package hip_pkg;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam logic [7:0] PROTO_RESET = 8'd139;
  localparam int unsigned LEN_W = 12;

  typedef struct packed {
    logic        command;
    logic        is_ipv6;
    logic [63:0] src_addr_high;
    logic [63:0] src_addr_low;
    logic [63:0] dst_addr_high;
    logic [63:0] dst_addr_low;
    logic [15:0] data_word;
    logic        last;
  } hip_in_t;

  typedef struct packed {
    logic [15:0] checksum;
    logic        checksum_ok;
    logic        too_short;
  } hip_out_t;

  typedef struct packed {
    logic        is_start;
    logic        add_en;
    logic [15:0] addend;
    logic        last;
    logic        too_short;
  } hip_entry_t;

  function automatic logic [15:0] oc_fold(input logic [19:0] x);
    logic [16:0] f;
    f = {1'b0, x[15:0]} + {13'b0, x[19:16]};
    return f[15:0] + {15'b0, f[16]};
  endfunction

endpackage

// ----- rtl/hip_front.sv -----
`timescale 1ns / 1ps

module hip_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hip_pkg::hip_in_t     in_data_i,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_data_i,
  output logic                 push_o,
  output hip_pkg::hip_entry_t  push_data_o,
  input  logic                 full_i
);

  logic [7:0]                  proto_q;
  logic                        s1_valid_q;
  logic                        s1_cmd_q;
  logic [15:0]                 s1_word_q;
  logic                        s1_last_q;
  logic [17:0]                 s1_part_q [4];
  logic [17:0]                 part_d [4];
  logic [15:0]                 w [16];
  logic [255:0]                addr_all;
  logic                        in_accept;

  logic                        first_q, first_d;
  logic [hip_pkg::LEN_W-1:0]   bytes_q, bytes_d;
  logic [hip_pkg::LEN_W-1:0]   exp_q, exp_d;

  logic [19:0]                 sum20;
  logic [8:0]                  len_units;
  logic [hip_pkg::LEN_W-1:0]   len;
  logic [hip_pkg::LEN_W-1:0]   exp_use;
  logic [17:0]                 pre18;
  logic [hip_pkg::LEN_W-1:0]   bytes_new;
  logic                        add_en;

  assign in_stall_o = s1_valid_q && full_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign push_o     = s1_valid_q && !full_i;

  assign addr_all = {in_data_i.src_addr_high, in_data_i.src_addr_low,
                     in_data_i.dst_addr_high, in_data_i.dst_addr_low};

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      if (in_data_i.is_ipv6 || k == 6 || k == 7 || k == 14 || k == 15) begin
        w[k] = addr_all[255 - 16*k -: 16];
      end else begin
        w[k] = 16'h0;
      end
    end
    for (int j = 0; j < 4; j++) begin
      part_d[j] = 18'(w[4*j]) + 18'(w[4*j+1]) + 18'(w[4*j+2]) + 18'(w[4*j+3]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_q <= hip_pkg::PROTO_RESET;
    end else if (cfg_we_i) begin
      proto_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (push_o) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cmd_q  <= in_data_i.command;
      s1_word_q <= in_data_i.data_word;
      s1_last_q <= in_data_i.last;
      s1_part_q <= part_d;
    end
  end

  always_comb begin
    sum20 = 20'(s1_part_q[0]) + 20'(s1_part_q[1]) + 20'(s1_part_q[2])
          + 20'(s1_part_q[3]);
    len_units = {1'b0, s1_word_q[7:0]} + 9'd1;
    len       = {len_units, 3'b000};
    exp_use   = first_q ? len : exp_q;
    add_en    = bytes_q < exp_use;
    bytes_new = add_en ? bytes_q + hip_pkg::LEN_W'(2) : bytes_q;
    pre18     = 18'(len) + 18'(proto_q) + 18'(s1_word_q);

    push_data_o = '0;
    first_d     = first_q;
    bytes_d     = bytes_q;
    exp_d       = exp_q;
    if (s1_cmd_q == hip_pkg::CMD_START) begin
      push_data_o.is_start = 1'b1;
      push_data_o.addend   = hip_pkg::oc_fold(sum20);
      first_d = 1'b1;
      bytes_d = '0;
      exp_d   = '0;
    end else begin
      push_data_o.add_en    = add_en;
      push_data_o.addend    = first_q ? hip_pkg::oc_fold({2'b0, pre18}) : s1_word_q;
      push_data_o.last      = s1_last_q;
      push_data_o.too_short = bytes_new < exp_use;
      if (s1_last_q) begin
        first_d = 1'b0;
        bytes_d = '0;
        exp_d   = '0;
      end else begin
        first_d = 1'b0;
        bytes_d = bytes_new;
        exp_d   = exp_use;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b0;
      bytes_q <= '0;
      exp_q   <= '0;
    end else if (push_o) begin
      first_q <= first_d;
      bytes_q <= bytes_d;
      exp_q   <= exp_d;
    end
  end

  a_bytes_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_q <= exp_q)
    else $error("byte count passed packet length");

endmodule

// ----- rtl/hip_queue.sv -----
`timescale 1ns / 1ps

module hip_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  hip_pkg::hip_entry_t  push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output hip_pkg::hip_entry_t  pop_data_o,
  output logic                 empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  hip_pkg::hip_entry_t mem_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;

  assign full_o     = count_q == CntW'(DEPTH);
  assign empty_o    = count_q == '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

// ----- rtl/hip_back.sv -----
`timescale 1ns / 1ps

module hip_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  output logic                 pop_o,
  input  hip_pkg::hip_entry_t  pop_data_i,
  input  logic                 empty_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hip_pkg::hip_out_t    out_data_o
);

  logic [15:0]        acc_q;
  logic [15:0]        acc_sum;
  logic [15:0]        acc_next;
  logic [15:0]        chk;
  logic               out_valid_q;
  hip_pkg::hip_out_t  out_q;

  assign pop_o = !empty_i && (!pop_data_i.last || !out_valid_q || !out_stall_i);

  always_comb begin
    acc_sum = hip_pkg::oc_fold({3'b0, {1'b0, acc_q} + {1'b0, pop_data_i.addend}});
    if (pop_data_i.is_start) begin
      acc_next = pop_data_i.addend;
    end else if (pop_data_i.add_en) begin
      acc_next = acc_sum;
    end else begin
      acc_next = acc_q;
    end
    chk = ~acc_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        acc_q <= pop_data_i.last ? 16'h0 : acc_next;
      end
      if (pop_o && pop_data_i.last) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && pop_data_i.last) begin
      out_q.checksum    <= chk;
      out_q.checksum_ok <= chk == 16'h0;
      out_q.too_short   <= pop_data_i.too_short;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && pop_data_i.last) |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && pop_data_i.last) |=> (acc_q == 16'h0 && out_valid_q))
    else $error("sum not cleared after final word");

endmodule

// ----- rtl/hip_pseudo_header_checksum.sv -----
`timescale 1ns / 1ps

// Internet checksum over a packet plus its IPv4/IPv6 pseudo-header.
// Input channel (in_valid_i / in_stall_o / in_data_i): a start request carries
// the address family and addresses; data requests follow, one 16-bit word
// each, with last on the final word. The packet length is read from the
// first data word and the protocol number from the configuration register.
// Output channel (out_valid_o / out_stall_i / out_data_o): one result per
// final word with checksum, checksum_ok and too_short.
// Throughput: one request per cycle, start or data, sustained while the queue is not full.
// A final word passes the input register, the queue and the output register;
// out_valid_o rises when the output register takes the result.
// A queue of QUEUE_DEPTH entries separates the classifying front from the
// summing back; when it fills, in_stall_o rises. While the receiver stalls,
// the result holds and data words still drain into the running sum; only a
// following final word waits.
// Reset: protocol number returns to 139, queue empties, all sums clear.
// cfg_we_i writes the protocol number; write it only while idle.
module hip_pseudo_header_checksum #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hip_pkg::hip_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hip_pkg::hip_out_t  out_data_o,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_data_i
);

  logic                 push;
  logic                 full;
  logic                 pop;
  logic                 empty;
  hip_pkg::hip_entry_t  push_data;
  hip_pkg::hip_entry_t  pop_data;

  hip_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  hip_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  hip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .empty_i     (empty),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- dv/hip_checksum_checker.sv -----
`timescale 1ns / 1ps

module hip_checksum_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  hip_pkg::hip_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  hip_pkg::hip_out_t out_data_i,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  import hip_pkg::*;

  logic [7:0]       proto_num;
  logic [15:0]      sum_acc;
  logic [LEN_W-1:0] bytes_summed;
  logic [LEN_W-1:0] frame_len;
  logic             len_pending;
  hip_out_t         expected_sums[$];

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

  function automatic logic [15:0] add_addr64(input logic [15:0] acc, input logic [63:0] a);
    logic [15:0] r;
    r = acc;
    for (int k = 3; k >= 0; k--) r = ones_add(r, a[k*16 +: 16]);
    return r;
  endfunction

  task automatic clear_packet();
    sum_acc      = '0;
    bytes_summed = '0;
    frame_len    = '0;
    len_pending  = 1'b0;
  endtask

  task automatic absorb_request(input hip_in_t req);
    hip_out_t res;
    if (req.command == CMD_START) begin
      clear_packet();
      if (req.is_ipv6) begin
        sum_acc = add_addr64(sum_acc, req.src_addr_high);
        sum_acc = add_addr64(sum_acc, req.src_addr_low);
        sum_acc = add_addr64(sum_acc, req.dst_addr_high);
        sum_acc = add_addr64(sum_acc, req.dst_addr_low);
      end else begin
        sum_acc = add_addr64(sum_acc, {32'h0, req.src_addr_low[31:0]});
        sum_acc = add_addr64(sum_acc, {32'h0, req.dst_addr_low[31:0]});
      end
      len_pending = 1'b1;
    end else begin
      if (len_pending) begin
        frame_len   = ({4'h0, req.data_word[7:0]} + 12'd1) << 3;
        sum_acc     = ones_add(sum_acc, 16'(frame_len));
        sum_acc     = ones_add(sum_acc, {8'h00, proto_num});
        len_pending = 1'b0;
      end
      if (bytes_summed < frame_len) begin
        sum_acc      = ones_add(sum_acc, req.data_word);
        bytes_summed = bytes_summed + 12'd2;
      end
      if (req.last) begin
        res.checksum    = ~sum_acc;
        res.checksum_ok = (~sum_acc == 16'h0000);
        res.too_short   = (bytes_summed < frame_len);
        expected_sums.push_back(res);
        clear_packet();
      end
    end
  endtask

  task automatic check_result(input hip_out_t got);
    hip_out_t want;
    if (expected_sums.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual %h", $time, got);
      fail_count_o++;
    end else begin
      want = expected_sums.pop_front();
      if (got.checksum !== want.checksum) begin
        $display("%0t: checksum mismatch: expected %h, actual %h",
                 $time, want.checksum, got.checksum);
        fail_count_o++;
      end
      if (got.checksum_ok !== want.checksum_ok) begin
        $display("%0t: checksum_ok mismatch: expected %b, actual %b",
                 $time, want.checksum_ok, got.checksum_ok);
        fail_count_o++;
      end
      if (got.too_short !== want.too_short) begin
        $display("%0t: too_short mismatch: expected %b, actual %b",
                 $time, want.too_short, got.too_short);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_num = PROTO_RESET;
      clear_packet();
      expected_sums.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (in_valid_i && !in_stall_i) absorb_request(in_data_i);
      if (cfg_we_i) proto_num = cfg_data_i;
    end
    pending_o = expected_sums.size();
  end

endmodule

// ----- dv/tb_hip_pseudo_header_checksum.sv -----
`timescale 1ns / 1ps

module tb_hip_pseudo_header_checksum;
  import hip_pkg::*;

  localparam int RANDOM_ITEMS     = 1200;
  localparam int PHASES           = 5;
  localparam int SETTLE_CYCLES    = 10;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT   = 5000;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_e;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  hip_in_t    in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  hip_out_t   out_data;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_data = '0;
  int         fail_count;
  int         pending;
  int         random_items = 0;
  int         burst_left = 0;
  int         quiet_cycles = 0;
  bit         long_hold_req = 1'b0;

  hip_pseudo_header_checksum i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  hip_checksum_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic logic [63:0] rnd64();
    return {32'($urandom), 32'($urandom)};
  endfunction

  function automatic hip_in_t start_req(input logic v6, input logic [63:0] sh,
                                        input logic [63:0] sl, input logic [63:0] dh,
                                        input logic [63:0] dl);
    hip_in_t r;
    r.command       = CMD_START;
    r.is_ipv6       = v6;
    r.src_addr_high = sh;
    r.src_addr_low  = sl;
    r.dst_addr_high = dh;
    r.dst_addr_low  = dl;
    r.data_word     = 16'($urandom);
    r.last          = 1'($urandom);
    return r;
  endfunction

  function automatic hip_in_t data_req(input logic [15:0] word, input logic last);
    hip_in_t r;
    r.command       = CMD_DATA;
    r.is_ipv6       = 1'($urandom);
    r.src_addr_high = rnd64();
    r.src_addr_low  = rnd64();
    r.dst_addr_high = rnd64();
    r.dst_addr_low  = rnd64();
    r.data_word     = word;
    r.last          = last;
    return r;
  endfunction

  task automatic send_request(input hip_in_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 40);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  // balance the pseudo-header so the sum folds to all ones
  task automatic send_verifying_packet(input logic [7:0] proto);
    logic [15:0] balance;
    balance = ~(16'd8 + {8'h00, proto});
    send_request(start_req(1'b0, rnd64(), {32'($urandom), 32'h0},
                           rnd64(), {32'($urandom), 32'h0}));
    send_request(data_req(16'h0000, 1'b0));
    send_request(data_req(balance, 1'b0));
    send_request(data_req(16'h0000, 1'b0));
    send_request(data_req(16'h0000, 1'b1));
  endtask

  task automatic send_random_packet();
    int          kind;
    int          len_code;
    int          frame_words;
    int          n_words;
    logic [15:0] word;
    logic        last;
    kind        = $urandom_range(0, 99);
    len_code    = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 255) : $urandom_range(0, 3);
    frame_words = (len_code + 1) * 4;
    if (len_code > 3) kind = 75;
    if (kind < 70) n_words = frame_words;
    else if (kind < 82) n_words = $urandom_range(1, (frame_words > 24) ? 24 : frame_words - 1);
    else if (kind < 90) n_words = frame_words + $urandom_range(1, 4);
    else if (kind < 95) n_words = $urandom_range(0, frame_words - 1);
    else n_words = $urandom_range(1, 6);
    if (kind < 95) begin
      send_request(start_req(1'($urandom), rnd64(), rnd64(), rnd64(), rnd64()));
      random_items++;
    end
    for (int k = 0; k < n_words; k++) begin
      word = (k == 0) ? {8'($urandom), 8'(len_code)} : 16'($urandom);
      last = (kind >= 90 && kind < 95) ? 1'b0 : (k == n_words - 1);
      send_request(data_req(word, last));
      random_items++;
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin : receiver
    stall_mode_e mode;
    int          mode_left;
    int          hold_left;
    mode      = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
          STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
          default:     out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [7:0] proto;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // data with no start
    send_request(data_req(16'h1234, 1'b0));
    send_request(data_req(16'hffff, 1'b1));
    send_request(start_req(1'b0, '1, '1, '1, '1));
    send_request(data_req(16'h0000, 1'b0));
    send_request(data_req(16'hffff, 1'b0));
    send_request(data_req(16'hffff, 1'b0));
    send_request(data_req(16'hffff, 1'b1));
    // longest length, ends early
    send_request(start_req(1'b1, '0, '0, '0, '0));
    send_request(data_req(16'hffff, 1'b0));
    send_request(data_req(16'h0001, 1'b1));
    // one surplus word
    send_request(start_req(1'b1, '1, '1, '1, '1));
    for (int k = 0; k < 5; k++)
      send_request(data_req((k == 0) ? 16'h0100 : 16'($urandom), k == 4));
    // drop a packet in progress
    send_request(start_req(1'b0, rnd64(), rnd64(), rnd64(), rnd64()));
    send_request(data_req(16'h0001, 1'b0));
    send_request(data_req(16'($urandom), 1'b0));
    send_verifying_packet(PROTO_RESET);

    for (int ph = 0; ph < PHASES; ph++) begin
      in_valid <= 1'b0;
      proto = (ph == 0) ? 8'd0 : (ph == 1) ? 8'd255 : 8'($urandom);
      while (pending != 0) @(negedge clk);
      repeat (SETTLE_CYCLES) @(negedge clk);
      cfg_we   <= 1'b1;
      cfg_data <= proto;
      @(negedge clk);
      cfg_we <= 1'b0;
      @(negedge clk);
      send_verifying_packet(proto);
      if (ph == 1) long_hold_req = 1'b1;
      while (random_items < (ph + 1) * RANDOM_ITEMS / PHASES) send_random_packet();
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/hip_pkg.sv
rtl/hip_front.sv
rtl/hip_queue.sv
rtl/hip_back.sv
rtl/hip_pseudo_header_checksum.sv
dv/hip_checksum_checker.sv
dv/tb_hip_pseudo_header_checksum.sv
